>>> rtl/core/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg: shared widths and types for the burst time statistics block
// Field widths, the serial step counter width and the sequencer states.
// ----------------------------------------------------------------------------
package bts_pkg;

	// field widths
	localparam int SAMPLE_BITS = 48;
	localparam int COUNT_BITS  = 32;
	localparam int SUM_BITS    = 64;

	// serial passes walk the full sum width, one bit per cycle
	localparam int STEP_W = $clog2(SUM_BITS);

	// top level sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_FINISH
	} bts_state_t;

endpackage

>>> rtl/core/bts_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_update: bit-serial statistics update
// Holds seen flag, count, total, minimum and maximum. One request is folded
// in LSB first, one bit per cycle: serial add into the total, serial
// compare against minimum and maximum, serial saturating count increment.
// ----------------------------------------------------------------------------
module bts_update import bts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] duration,
	output logic                   done,
	output logic                   seen,
	output logic [COUNT_BITS-1:0]  count,
	output logic [SUM_BITS-1:0]    sum,
	output logic [SAMPLE_BITS-1:0] min_val,
	output logic [SAMPLE_BITS-1:0] max_val
);

	logic                   busy_q;
	logic                   fin_q;
	logic                   done_q;
	logic [STEP_W-1:0]      step_q;
	logic [SAMPLE_BITS-1:0] dur_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic                   seen_q;
	logic                   carry_q;
	logic                   inc_q;
	logic                   lt_q;
	logic                   gt_q;

	logic in_smp;
	logic in_cnt;
	logic add_b;
	logic sum_bit;
	logic carry_d;
	logic last_step;

	// which bit positions are live this step
	always_comb begin
		in_smp    = {1'b0, step_q} < (STEP_W + 1)'(SAMPLE_BITS);
		in_cnt    = {1'b0, step_q} < (STEP_W + 1)'(COUNT_BITS);
		add_b     = in_smp & dur_q[0];
		sum_bit   = sum_q[0] ^ add_b ^ carry_q;
		carry_d   = (sum_q[0] & add_b) | (sum_q[0] & carry_q) | (add_b & carry_q);
		last_step = step_q == STEP_W'(SUM_BITS - 1);
	end

	// serial datapath and statistics registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
			dur_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			seen_q  <= 1'b0;
			carry_q <= 1'b0;
			inc_q   <= 1'b0;
			lt_q    <= 1'b0;
			gt_q    <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q & ~start & last_step;
			if (start) begin
				busy_q  <= 1'b1;
				step_q  <= '0;
				dur_q   <= duration;
				carry_q <= 1'b0;
				inc_q   <= ~&cnt_q;
				lt_q    <= 1'b0;
				gt_q    <= 1'b0;
			end else if (busy_q) begin
				// total: serial add, rotate right
				sum_q   <= {sum_bit, sum_q[SUM_BITS-1:1]};
				carry_q <= carry_d;
				// min / max compare, last differing bit decides
				if (in_smp) begin
					dur_q <= {dur_q[0], dur_q[SAMPLE_BITS-1:1]};
					min_q <= {min_q[0], min_q[SAMPLE_BITS-1:1]};
					max_q <= {max_q[0], max_q[SAMPLE_BITS-1:1]};
					if (dur_q[0] != min_q[0]) begin
						lt_q <= ~dur_q[0];
					end
					if (dur_q[0] != max_q[0]) begin
						gt_q <= dur_q[0];
					end
				end
				// count: serial increment, suppressed when full
				if (in_cnt) begin
					cnt_q <= {cnt_q[0] ^ inc_q, cnt_q[COUNT_BITS-1:1]};
					inc_q <= cnt_q[0] & inc_q;
				end
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end else if (fin_q) begin
				// commit min / max and saturate the total
				if (!seen_q || lt_q) begin
					min_q <= dur_q;
				end
				if (!seen_q || gt_q) begin
					max_q <= dur_q;
				end
				if (carry_q) begin
					sum_q <= '1;
				end
				seen_q <= 1'b1;
			end
		end
	end

	assign done    = done_q;
	assign seen    = seen_q;
	assign count   = cnt_q;
	assign sum     = sum_q;
	assign min_val = min_q;
	assign max_val = max_q;

endmodule

>>> rtl/core/bts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_div: bit-serial restoring divider for the mean
// Total divided by count, one quotient bit per cycle, MSB first. The
// quotient saturates at the largest sample value.
// ----------------------------------------------------------------------------
module bts_div import bts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SUM_BITS-1:0]    dividend,
	input  logic [COUNT_BITS-1:0]  divisor,
	output logic                   done,
	output logic [SAMPLE_BITS-1:0] quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [SUM_BITS-1:0]   num_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;

	logic [COUNT_BITS:0]   trial;
	logic                  ge;
	logic [COUNT_BITS:0]   diff;
	logic [SUM_BITS-1:0]   high_part;

	// one restoring step
	always_comb begin
		trial = {rem_q, num_q[SUM_BITS-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= busy_q & ~start & (step_q == STEP_W'(SUM_BITS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				num_q  <= {num_q[SUM_BITS-2:0], ge};
				rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// saturate to the sample range
	always_comb begin
		high_part = num_q >> SAMPLE_BITS;
		quotient  = (high_part != '0) ? '1 : num_q[SAMPLE_BITS-1:0];
	end

	assign done = done_q;

endmodule

>>> rtl/core/burst_time_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_time_statistics: running min / max / mean over burst durations
// Keeps count, total, minimum, maximum and mean of nonzero durations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with duration. A request is taken at
//   a clock edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with accepted, has_samples,
//   sample_count, total_dur, min_dur, max_dur and mean_time. Exactly one
//   result per request, in request order.
//   A nonzero duration is folded in bit-serially over the 64-bit total,
//   then the mean comes from a bit-serial restoring divider, and the
//   sequencer then loads the result register. A zero duration is ignored
//   and goes straight to the finish state, which loads its result. One
//   request is in work at a time, so the next request is taken only after
//   the result of the last one has been loaded into the output register.
//   The result sits in an output register: the next request is taken while
//   it still waits. If out_stall holds, the next result waits in the
//   sequencer and in_stall stays high until the output register frees.
//   Reset (arst_n low) clears all statistics to zero and drops out_valid.
// ----------------------------------------------------------------------------
module burst_time_statistics import bts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] duration,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   accepted,
	output logic                   has_samples,
	output logic [COUNT_BITS-1:0]  sample_count,
	output logic [SUM_BITS-1:0]    total_dur,
	output logic [SAMPLE_BITS-1:0] min_dur,
	output logic [SAMPLE_BITS-1:0] max_dur,
	output logic [SAMPLE_BITS-1:0] mean_time
);

	bts_state_t state_q;
	bts_state_t state_d;

	logic                   acc_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic                   out_valid_q;
	logic                   out_acc_q;
	logic                   out_seen_q;
	logic [COUNT_BITS-1:0]  out_count_q;
	logic [SUM_BITS-1:0]    out_sum_q;
	logic [SAMPLE_BITS-1:0] out_min_q;
	logic [SAMPLE_BITS-1:0] out_max_q;
	logic [SAMPLE_BITS-1:0] out_mean_q;

	logic                   in_take;
	logic                   nonzero;
	logic                   upd_start;
	logic                   upd_done;
	logic                   div_start;
	logic                   div_done;
	logic                   out_free;
	logic                   out_load;
	logic                   seen;
	logic [COUNT_BITS-1:0]  count;
	logic [SUM_BITS-1:0]    sum;
	logic [SAMPLE_BITS-1:0] min_val;
	logic [SAMPLE_BITS-1:0] max_val;
	logic [SAMPLE_BITS-1:0] quotient;

	// statistics update unit
	bts_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (upd_start),
		.duration (duration),
		.done     (upd_done),
		.seen     (seen),
		.count    (count),
		.sum      (sum),
		.min_val  (min_val),
		.max_val  (max_val)
	);

	// mean divider
	bts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum),
		.divisor  (count),
		.done     (div_done),
		.quotient (quotient)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencing strobes
	always_comb begin
		in_stall  = state_q != ST_IDLE;
		in_take   = in_valid && state_q == ST_IDLE;
		nonzero   = duration != '0;
		out_free  = !out_valid_q || !out_stall;
		upd_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					upd_start = nonzero;
					state_d   = nonzero ? ST_UPDATE : ST_FINISH;
				end
			end
			ST_UPDATE: begin
				if (upd_done) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// accepted flag of the request in work, and the mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 1'b0;
			mean_q <= '0;
		end else begin
			if (in_take) begin
				acc_q <= nonzero;
			end
			if (div_done) begin
				mean_q <= quotient;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_acc_q   <= acc_q;
			out_seen_q  <= seen;
			out_count_q <= count;
			out_sum_q   <= sum;
			out_min_q   <= min_val;
			out_max_q   <= max_val;
			out_mean_q  <= mean_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = out_acc_q;
	assign has_samples  = out_seen_q;
	assign sample_count = out_count_q;
	assign total_dur    = out_sum_q;
	assign min_dur      = out_min_q;
	assign max_dur      = out_max_q;
	assign mean_time    = out_mean_q;

endmodule

>>> verif/burst_time_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_time_statistics_tb: regression for the burst time statistics block
// Sends burst durations and predicts the running count, total, minimum,
// maximum and mean for each request. Every result is checked field by field
// against the oldest prediction. Both sides idle at random, and one phase
// holds off the result side long enough to back the block up.
// ----------------------------------------------------------------------------
module burst_time_statistics_tb;
	import bts_pkg::*;

	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 11;
	localparam int MAX_WAIT       = 12;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 160;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int STRETCH_ITEMS  = 50;

	localparam logic [SAMPLE_BITS-1:0] DUR_MAX    = '1;
	localparam logic [SUM_BITS-1:0]    SAMPLE_MAX = {{(SUM_BITS-SAMPLE_BITS){1'b0}}, DUR_MAX};

	// one set of statistics as the block reports it
	typedef struct packed {
		logic                   accepted;
		logic                   has_samples;
		logic [COUNT_BITS-1:0]  sample_count;
		logic [SUM_BITS-1:0]    total_dur;
		logic [SAMPLE_BITS-1:0] min_dur;
		logic [SAMPLE_BITS-1:0] max_dur;
		logic [SAMPLE_BITS-1:0] mean_time;
	} stats_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] duration;
	logic                   out_valid;
	logic                   out_stall;
	logic                   accepted;
	logic                   has_samples;
	logic [COUNT_BITS-1:0]  sample_count;
	logic [SUM_BITS-1:0]    total_dur;
	logic [SAMPLE_BITS-1:0] min_dur;
	logic [SAMPLE_BITS-1:0] max_dur;
	logic [SAMPLE_BITS-1:0] mean_time;

	// running statistics as predicted
	logic                   run_seen;
	logic [COUNT_BITS-1:0]  run_count;
	logic [SUM_BITS-1:0]    run_sum;
	logic [SAMPLE_BITS-1:0] run_min;
	logic [SAMPLE_BITS-1:0] run_max;
	logic [SAMPLE_BITS-1:0] run_mean;

	stats_t expected_stats[$];
	int     err_count;
	bit     send_idle_on;
	bit     sink_idle_on;
	bit     hold_request;

	burst_time_statistics u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.duration     (duration),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accepted     (accepted),
		.has_samples  (has_samples),
		.sample_count (sample_count),
		.total_dur    (total_dur),
		.min_dur      (min_dur),
		.max_dur      (max_dur),
		.mean_time    (mean_time)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// wait length for one request on either side
	function automatic int draw_wait(input bit enabled);
		return enabled ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	// fold one duration into the running statistics and queue the result
	function automatic void predict_stats(input logic [SAMPLE_BITS-1:0] d);
		stats_t              e;
		logic [SUM_BITS:0]   wide_sum;
		logic [SUM_BITS-1:0] quot;
		e.accepted = (d != '0);
		if (e.accepted) begin
			wide_sum = {1'b0, run_sum} + d;
			run_sum  = wide_sum[SUM_BITS] ? '1 : wide_sum[SUM_BITS-1:0];
			if (!run_seen) begin
				run_min = d;
				run_max = d;
			end else begin
				if (d > run_max) run_max = d;
				if (d < run_min) run_min = d;
			end
			run_seen = 1'b1;
			if (run_count != '1) run_count = run_count + 1'b1;
			quot     = run_sum / run_count;
			run_mean = (quot > SAMPLE_MAX) ? DUR_MAX : quot[SAMPLE_BITS-1:0];
		end
		e.has_samples  = run_seen;
		e.sample_count = run_count;
		e.total_dur    = run_sum;
		e.min_dur      = run_min;
		e.max_dur      = run_max;
		e.mean_time    = run_mean;
		expected_stats.push_back(e);
	endfunction

	// random duration, weighted toward the interesting corners
	function automatic logic [SAMPLE_BITS-1:0] rand_duration();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DUR_MAX;
			2: return SAMPLE_BITS'($urandom_range(1, 255));
			3: return SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
			7: return SAMPLE_BITS'(r[23:0]);
			8: return DUR_MAX - SAMPLE_BITS'($urandom_range(0, 255));
			9: return r[SAMPLE_BITS-1:0] >> $urandom_range(0, SAMPLE_BITS - 1);
			default: return r[SAMPLE_BITS-1:0];
		endcase
	endfunction

	// send one request; entered and left at a falling edge, valid left high
	task automatic send_duration(input logic [SAMPLE_BITS-1:0] d);
		int gap;
		gap = draw_wait(send_idle_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		duration <= d;
		do @(posedge clk); while (in_stall);
		predict_stats(d);
		@(negedge clk);
	endtask

	// stop sending and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_stats.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// corners: empty statistics, extremes, zero after samples, bit patterns
	task automatic test_directed();
		logic [SAMPLE_BITS-1:0] pat[$];
		pat = '{'0, DUR_MAX, '0, SAMPLE_BITS'(1), SAMPLE_BITS'(2), DUR_MAX - 1, '0,
			{(SAMPLE_BITS/2){2'b10}}, {(SAMPLE_BITS/2){2'b01}},
			SAMPLE_BITS'(1) << (SAMPLE_BITS - 1), SAMPLE_BITS'(1),
			SAMPLE_BITS'(1000), '0, DUR_MAX};
		send_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		foreach (pat[i]) send_duration(pat[i]);
		send_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (8) send_duration(rand_duration());
		wait_drained();
	endtask

	// result side held off while requests keep coming back to back
	task automatic test_backpressure();
		send_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (8) send_duration(rand_duration());
		wait_drained();
	endtask

	// sender pauses until the block has returned everything
	task automatic test_drain_pause();
		send_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (10) send_duration(rand_duration());
		wait_drained();
		repeat (draw_wait(1'b1)) @(negedge clk);
		repeat (10) send_duration(rand_duration());
		wait_drained();
	endtask

	// random durations, idling switched on and off in stretches
	task automatic test_random();
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % STRETCH_ITEMS == 0) begin
				send_idle_on = ($urandom_range(0, 3) != 0);
				sink_idle_on = ($urandom_range(0, 3) != 0);
			end
			send_duration(rand_duration());
		end
		wait_drained();
	endtask

	// result side: random stall per result, one long hold-off on request
	initial begin : result_sink
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			n = hold_request ? HOLD_CYCLES : draw_wait(sink_idle_on);
			hold_request = 1'b0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		stats_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_stats.size() == 0) begin
				$error("result with no request outstanding");
				err_count++;
			end else begin
				e = expected_stats.pop_front();
				if (accepted !== e.accepted) begin
					$error("accepted: expected %0d, got %0d", e.accepted, accepted);
					err_count++;
				end
				if (has_samples !== e.has_samples) begin
					$error("has_samples: expected %0d, got %0d", e.has_samples, has_samples);
					err_count++;
				end
				if (sample_count !== e.sample_count) begin
					$error("sample_count: expected %0d, got %0d", e.sample_count, sample_count);
					err_count++;
				end
				if (total_dur !== e.total_dur) begin
					$error("total_dur: expected %0d, got %0d", e.total_dur, total_dur);
					err_count++;
				end
				if (min_dur !== e.min_dur) begin
					$error("min_dur: expected %0d, got %0d", e.min_dur, min_dur);
					err_count++;
				end
				if (max_dur !== e.max_dur) begin
					$error("max_dur: expected %0d, got %0d", e.max_dur, max_dur);
					err_count++;
				end
				if (mean_time !== e.mean_time) begin
					$error("mean_time: expected %0d, got %0d", e.mean_time, mean_time);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("burst_time_statistics regression: fail");
		$finish;
	end

	// test sequence
	initial begin : main_seq
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		duration     = '0;
		err_count    = 0;
		send_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_request = 1'b0;
		run_seen     = 1'b0;
		run_count    = '0;
		run_sum      = '0;
		run_min      = '0;
		run_max      = '0;
		run_mean     = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random();

		// catch late or stray results
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_count == 0 && expected_stats.size() == 0) begin
			$display("burst_time_statistics regression: pass");
		end else begin
			$display("burst_time_statistics regression: fail");
		end
		$finish;
	end

endmodule
